[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module of the sequencer.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define MNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Consequent holds in the cycle after the antecedent.
`define MNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

[hw/rtl/mns_pkg.sv]
// Types and codes of the melody note sequencer.
// Used by the top level, the tone and note store, and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mns_pkg;

  typedef enum logic [3:0] {
    CMD_TICK     = 4'd0,
    CMD_PLAY     = 4'd1,
    CMD_PAUSE    = 4'd2,
    CMD_TOGGLE   = 4'd3,
    CMD_NEXT     = 4'd4,
    CMD_REPLAY   = 4'd5,
    CMD_INIT     = 4'd6,
    CMD_WR_NOTE  = 4'd7,
    CMD_WR_TONE  = 4'd8,
    CMD_WR_SONG  = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NOTE,
    ST_TONE
  } state_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [3:0]  song_sel;
    logic [7:0]  entry_index;
    logic [5:0]  note_tone;
    logic [15:0] note_beats;
    logic [15:0] reload_word;
    logic [7:0]  last_note;
    logic [15:0] beat_ticks;
    logic [15:0] gap_ticks;
  } in_t;

  typedef struct packed {
    logic [15:0] tone_reload;
    logic        buzz_on;
    logic        playing;
    logic [3:0]  song_idx;
    logic [7:0]  note_now;
    logic        resting;
  } out_t;

  typedef struct packed {
    logic [7:0]  last;
    logic [15:0] beat;
    logic [15:0] gap;
  } song_t;

  localparam int unsigned NoteW = 22;
  localparam int unsigned ToneW = 16;

endpackage

`default_nettype wire

[hw/rtl/mns_store.sv]
// Note and tone memories of the sequencer, one write and one registered read port each.
// Depends on mns_pkg for the entry widths.
`timescale 1ns / 1ps
`default_nettype none

module mns_store
  import mns_pkg::*;
#(
  parameter int unsigned NOTE_DEPTH = 768,
  parameter int unsigned TONE_DEPTH = 192
) (
  input  wire logic                          clk_i,
  input  wire logic                          note_we_i,
  input  wire logic [$clog2(NOTE_DEPTH)-1:0] note_waddr_i,
  input  wire logic [NoteW-1:0]              note_wdata_i,
  input  wire logic                          note_re_i,
  input  wire logic [$clog2(NOTE_DEPTH)-1:0] note_raddr_i,
  output logic      [NoteW-1:0]              note_rdata_o,
  input  wire logic                          tone_we_i,
  input  wire logic [$clog2(TONE_DEPTH)-1:0] tone_waddr_i,
  input  wire logic [ToneW-1:0]              tone_wdata_i,
  input  wire logic                          tone_re_i,
  input  wire logic [$clog2(TONE_DEPTH)-1:0] tone_raddr_i,
  output logic      [ToneW-1:0]              tone_rdata_o
);

  logic [NoteW-1:0] note_mem [NOTE_DEPTH];
  logic [ToneW-1:0] tone_mem [TONE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (note_we_i) begin
      note_mem[note_waddr_i] <= note_wdata_i;
    end
    if (note_re_i) begin
      note_rdata_o <= note_mem[note_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tone_we_i) begin
      tone_mem[tone_waddr_i] <= tone_wdata_i;
    end
    if (tone_re_i) begin
      tone_rdata_o <= tone_mem[tone_raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/melody_note_sequencer.sv]
// Melody note sequencer: plays songs from loaded note, tone and song tables.
// Depends on mns_pkg and mns_store.
//
// Every input beat yields one output beat with the tone reload, buzzer enable and position.
// An input register takes the next beat while the current one is being worked on, and an
// output register holds the result until it is taken. Writes and commands that load no note
// produce their result straight from the accepted beat; a command that loads a note first reads
// the note memory and then, when the note is not a rest, the tone memory. The memories have no
// clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module melody_note_sequencer
  import mns_pkg::*;
#(
  parameter int unsigned NUM_SONGS      = 3,
  parameter int unsigned NOTES_PER_SONG = 256,
  parameter int unsigned TONE_CODES     = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned NoteDepth = NUM_SONGS * NOTES_PER_SONG;
  localparam int unsigned ToneDepth = NUM_SONGS * TONE_CODES;
  localparam int unsigned NoteAw    = $clog2(NoteDepth);
  localparam int unsigned ToneAw    = $clog2(ToneDepth);
  localparam int unsigned SiW       = (NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1;

  state_e state_q, state_d;
  logic pend_valid_q, pend_valid_d;
  in_t  pend_q;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic [3:0]  song_q, song_d;
  logic [7:0]  note_q, note_d;
  logic [15:0] beats_q, beats_d;
  logic [15:0] div_q, div_d;
  logic [15:0] gap_q, gap_d;
  logic        rest_q, rest_d;
  logic [15:0] reload_q, reload_d;
  logic        buzz_q, buzz_d;
  logic        play_q, play_d;
  logic        set_beats_q, set_beats_d;
  song_t       cur_q, cur_d;

  song_t song_tbl [NUM_SONGS];
  song_t tbl_rd;
  logic [SiW-1:0] tbl_idx;
  logic tbl_we;

  logic              note_we, note_re, tone_we, tone_re;
  logic [NoteAw-1:0] note_waddr, note_raddr;
  logic [ToneAw-1:0] tone_waddr, tone_raddr;
  logic [NoteW-1:0]  note_rdata;
  logic [ToneW-1:0]  tone_rdata;

  logic pend_take;

  assign in_ready_o  = !pend_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tbl_rd = song_tbl[tbl_idx];

  mns_store #(
    .NOTE_DEPTH(NoteDepth),
    .TONE_DEPTH(ToneDepth)
  ) u_store (
    .clk_i       (clk_i),
    .note_we_i   (note_we),
    .note_waddr_i(note_waddr),
    .note_wdata_i({pend_q.note_tone, pend_q.note_beats}),
    .note_re_i   (note_re),
    .note_raddr_i(note_raddr),
    .note_rdata_o(note_rdata),
    .tone_we_i   (tone_we),
    .tone_waddr_i(tone_waddr),
    .tone_wdata_i(pend_q.reload_word),
    .tone_re_i   (tone_re),
    .tone_raddr_i(tone_raddr),
    .tone_rdata_o(tone_rdata)
  );

  always_comb begin
    cmd_e        cmd;
    logic [3:0]  song_inc;
    logic [15:0] div_dec;
    logic [15:0] beats_n;
    logic [5:0]  tone;
    logic        load;
    logic        new_song;
    logic        finish;

    cmd      = cmd_e'(pend_q.command);
    song_inc = (song_q == 4'(NUM_SONGS - 1)) ? 4'd0 : song_q + 4'd1;
    div_dec  = div_q - 16'd1;
    beats_n  = beats_q;
    tone     = note_rdata[21:16];
    load     = 1'b0;
    new_song = 1'b0;
    finish   = 1'b0;

    state_d     = state_q;
    song_d      = song_q;
    note_d      = note_q;
    beats_d     = beats_q;
    div_d       = div_q;
    gap_d       = gap_q;
    rest_d      = rest_q;
    reload_d    = reload_q;
    buzz_d      = buzz_q;
    play_d      = play_q;
    set_beats_d = set_beats_q;
    cur_d       = cur_q;
    pend_take   = 1'b0;
    tbl_idx     = (cmd == CMD_INIT) ? '0 : song_inc[SiW-1:0];
    tbl_we      = 1'b0;
    note_we     = 1'b0;
    tone_we     = 1'b0;
    note_re     = 1'b0;
    tone_re     = 1'b0;
    note_waddr  = NoteAw'(int'(pend_q.song_sel) * NOTES_PER_SONG + int'(pend_q.entry_index));
    tone_waddr  = ToneAw'(int'(pend_q.song_sel) * TONE_CODES + int'(pend_q.entry_index));
    note_raddr  = '0;
    tone_raddr  = ToneAw'(int'(song_q) * TONE_CODES + int'(tone));

    unique case (state_q)
      ST_IDLE: begin
        if (pend_valid_q && (!out_valid_q || out_ready_i)) begin
          pend_take = 1'b1;
          unique case (cmd)
            CMD_TICK: begin
              if (play_q) begin
                if (gap_q != 16'd0) begin
                  gap_d = gap_q - 16'd1;
                end else if (!rest_q) begin
                  buzz_d = 1'b1;
                end
                div_d = div_dec;
                if (div_dec == 16'd0) begin
                  beats_n = beats_q - 16'd1;
                  div_d   = cur_q.beat;
                end
                beats_d = beats_n;
                if (beats_n == 16'd0) begin
                  gap_d       = cur_q.gap;
                  load        = 1'b1;
                  set_beats_d = 1'b1;
                  if (note_q < cur_q.last && note_q != 8'(NOTES_PER_SONG - 1)) begin
                    note_d = note_q + 8'd1;
                  end else begin
                    new_song = 1'b1;
                  end
                end
              end
            end
            CMD_PLAY: begin
              play_d      = 1'b1;
              load        = 1'b1;
              set_beats_d = 1'b0;
            end
            CMD_PAUSE: begin
              play_d = 1'b0;
              buzz_d = 1'b0;
            end
            CMD_TOGGLE: begin
              if (play_q) begin
                play_d = 1'b0;
                buzz_d = 1'b0;
              end else begin
                play_d      = 1'b1;
                load        = 1'b1;
                set_beats_d = 1'b0;
              end
            end
            CMD_NEXT: begin
              new_song    = 1'b1;
              load        = 1'b1;
              set_beats_d = 1'b1;
            end
            CMD_REPLAY: begin
              note_d      = 8'd0;
              div_d       = cur_q.beat;
              load        = 1'b1;
              set_beats_d = 1'b1;
            end
            CMD_INIT: begin
              new_song    = 1'b1;
              play_d      = 1'b0;
              load        = 1'b1;
              set_beats_d = 1'b1;
            end
            CMD_WR_NOTE: begin
              note_we = ({1'b0, pend_q.song_sel} < 5'(NUM_SONGS)) &&
                        ({1'b0, pend_q.entry_index} < 9'(NOTES_PER_SONG));
            end
            CMD_WR_TONE: begin
              tone_we = ({1'b0, pend_q.song_sel} < 5'(NUM_SONGS)) &&
                        ({1'b0, pend_q.entry_index} < 9'(TONE_CODES));
            end
            CMD_WR_SONG: begin
              if ({1'b0, pend_q.song_sel} < 5'(NUM_SONGS)) begin
                tbl_we = 1'b1;
                if (pend_q.song_sel == song_q) begin
                  cur_d = '{last: pend_q.last_note, beat: pend_q.beat_ticks,
                            gap: pend_q.gap_ticks};
                end
              end
            end
            default: begin
            end
          endcase

          if (new_song) begin
            song_d = (cmd == CMD_INIT) ? 4'd0 : song_inc;
            note_d = 8'd0;
            cur_d  = tbl_rd;
            div_d  = tbl_rd.beat;
          end

          if (load) begin
            buzz_d     = 1'b0;
            note_re    = 1'b1;
            note_raddr = NoteAw'(int'(song_d) * NOTES_PER_SONG + int'(note_d));
            state_d    = ST_NOTE;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_NOTE: begin
        if (set_beats_q) begin
          beats_d = note_rdata[15:0];
        end
        if (tone != 6'd0 && {1'b0, tone} < 7'(TONE_CODES)) begin
          tone_re = 1'b1;
          state_d = ST_TONE;
        end else begin
          rest_d  = 1'b1;
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TONE: begin
        reload_d = tone_rdata;
        rest_d   = 1'b0;
        finish   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d = '{tone_reload: reload_d, buzz_on: buzz_d, playing: play_d, song_idx: song_d,
              note_now: note_d, resting: rest_d};
    out_valid_d = finish ? 1'b1 : (out_valid_q && !out_ready_i);

    if (in_valid_i && !pend_valid_q) begin
      pend_valid_d = 1'b1;
    end else if (pend_take) begin
      pend_valid_d = 1'b0;
    end else begin
      pend_valid_d = pend_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      song_q       <= '0;
      note_q       <= '0;
      beats_q      <= '0;
      div_q        <= '0;
      gap_q        <= '0;
      rest_q       <= 1'b0;
      reload_q     <= '0;
      buzz_q       <= 1'b0;
      play_q       <= 1'b0;
      set_beats_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      song_q       <= song_d;
      note_q       <= note_d;
      beats_q      <= beats_d;
      div_q        <= div_d;
      gap_q        <= gap_d;
      rest_q       <= rest_d;
      reload_q     <= reload_d;
      buzz_q       <= buzz_d;
      play_q       <= play_d;
      set_beats_q  <= set_beats_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !pend_valid_q) begin
      pend_q <= in_data_i;
    end
    if (out_valid_d && (!out_valid_q || out_ready_i)) begin
      out_q <= out_d;
    end
    cur_q <= cur_d;
    if (tbl_we) begin
      song_tbl[pend_q.song_sel[SiW-1:0]] <= '{last: pend_q.last_note,
                                              beat: pend_q.beat_ticks,
                                              gap: pend_q.gap_ticks};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mns_checker.sv]
// Port-level checks of the melody note sequencer, bound to the top level.
// Depends on mns_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mns_checker
  import mns_pkg::*;
#(
  parameter int unsigned NUM_SONGS = 3
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  logic in_stall;
  logic out_stall;
  logic in_taken;
  logic buzz_bad;
  logic song_ok;

  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign in_taken  = in_valid_i && in_ready_o;
  assign buzz_bad  = out_data_o.buzz_on && (out_data_o.resting || !out_data_o.playing);
  assign song_ok   = {1'b0, out_data_o.song_idx} < 5'(NUM_SONGS);

  // A waiting input beat stays put.
  `MNS_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_data_i))

  // A stalled result beat stays put.
  `MNS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // The input register holds one beat, so an accepted beat closes the input side until it is taken.
  `MNS_ASSERT_NXT(a_in_one_deep, clk_i, rst_ni, in_taken, !in_ready_o)

  // The buzzer sounds only while playing a note that is not a rest.
  `MNS_ASSERT_IMP(a_buzz_legal, clk_i, rst_ni, out_valid_o, !buzz_bad)

  // The song position never leaves the configured song range.
  `MNS_ASSERT_IMP(a_song_range, clk_i, rst_ni, out_valid_o, song_ok)

endmodule

bind melody_note_sequencer mns_checker #(.NUM_SONGS(NUM_SONGS)) u_mns_checker (.*);

`default_nettype wire

[bench/melody_note_sequencer_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for melody_note_sequencer: sends command beats, predicts the status beat
// of each one and compares the status beats in order. Depends on mns_pkg and the sequencer RTL.

module melody_note_sequencer_tb;
  import mns_pkg::*;

  localparam int unsigned NumSongs     = 3;
  localparam int unsigned NotesPerSong = 256;
  localparam int unsigned ToneCodes    = 64;
  localparam int unsigned MaxSel       = 15;
  localparam int unsigned UnusedCmdLo  = int'(CMD_WR_SONG) + 1;
  localparam int unsigned UnusedCmdHi  = 15;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxReports   = 10;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  always #2 clk = ~clk;

  melody_note_sequencer #(
    .NUM_SONGS     (NumSongs),
    .NOTES_PER_SONG(NotesPerSong),
    .TONE_CODES    (ToneCodes)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Predicted contents of the tables and the playback position.
  logic [NoteW-1:0] note_mem [NumSongs*NotesPerSong];
  logic [ToneW-1:0] tone_mem [NumSongs*ToneCodes];
  song_t            song_mem [NumSongs];
  bit               note_set [NumSongs*NotesPerSong];
  bit               tone_set [NumSongs*ToneCodes];
  int unsigned      note_fill [NumSongs];

  logic [3:0]  cur_song   = '0;
  logic [7:0]  cur_pos    = '0;
  logic [15:0] beats_left = '0;
  logic [15:0] beat_div   = '0;
  logic [15:0] gap_left   = '0;
  logic [15:0] reload_val = '0;
  logic        rest_on    = 1'b0;
  logic        buzz_val   = 1'b0;
  logic        play_on    = 1'b0;

  out_t        pending_status [$];
  int unsigned errors      = 0;
  int unsigned stall_count = 0;
  int unsigned src_idle    = 15;
  int unsigned sink_idle   = 63;
  int unsigned hold_asked  = 0;
  int unsigned hold_taken  = 0;
  int unsigned hold_left   = 0;

  function automatic logic [NoteW-1:0] note_word();
    return note_mem[cur_song * NotesPerSong + cur_pos];
  endfunction

  function automatic void load_tone();
    logic [NoteW-1:0] word;
    word = note_word();
    if (word[21:16] != '0 && word[21:16] < ToneCodes) begin
      reload_val = tone_mem[cur_song * ToneCodes + word[21:16]];
      rest_on = 1'b0;
    end else begin
      rest_on = 1'b1;
    end
    buzz_val = 1'b0;
  endfunction

  function automatic void start_song();
    logic [NoteW-1:0] word;
    cur_pos = '0;
    word = note_word();
    beats_left = word[15:0];
    beat_div = song_mem[cur_song].beat;
  endfunction

  function automatic void next_song();
    cur_song = (cur_song + 1 < NumSongs) ? cur_song + 4'd1 : '0;
    start_song();
    load_tone();
  endfunction

  function automatic void next_note();
    logic [NoteW-1:0] word;
    buzz_val = 1'b0;
    gap_left = song_mem[cur_song].gap;
    if (cur_pos < song_mem[cur_song].last && cur_pos + 1 < NotesPerSong) begin
      cur_pos = cur_pos + 8'd1;
    end else begin
      next_song();
    end
    word = note_word();
    beats_left = word[15:0];
    load_tone();
  endfunction

  function automatic out_t play_beat(in_t b);
    out_t        r;
    int unsigned idx;
    case (b.command)
      CMD_TICK: if (play_on) begin
        if (gap_left != '0) gap_left = gap_left - 16'd1;
        else if (!rest_on) buzz_val = 1'b1;
        beat_div = beat_div - 16'd1;
        if (beat_div == '0) begin
          beats_left = beats_left - 16'd1;
          beat_div = song_mem[cur_song].beat;
        end
        if (beats_left == '0) next_note();
      end
      CMD_PLAY: begin
        play_on = 1'b1;
        load_tone();
      end
      CMD_PAUSE: begin
        buzz_val = 1'b0;
        play_on = 1'b0;
      end
      CMD_TOGGLE: begin
        if (play_on) begin
          buzz_val = 1'b0;
          play_on = 1'b0;
        end else begin
          play_on = 1'b1;
          load_tone();
        end
      end
      CMD_NEXT: next_song();
      CMD_REPLAY: begin
        start_song();
        load_tone();
      end
      CMD_INIT: begin
        cur_song = '0;
        start_song();
        load_tone();
        play_on = 1'b0;
        buzz_val = 1'b0;
      end
      CMD_WR_NOTE: if (b.song_sel < NumSongs && b.entry_index < NotesPerSong) begin
        idx = b.song_sel * NotesPerSong + b.entry_index;
        note_mem[idx] = {b.note_tone, b.note_beats};
        note_set[idx] = 1'b1;
        while (note_fill[b.song_sel] < NotesPerSong &&
               note_set[b.song_sel * NotesPerSong + note_fill[b.song_sel]]) begin
          note_fill[b.song_sel]++;
        end
      end
      CMD_WR_TONE: if (b.song_sel < NumSongs && b.entry_index < ToneCodes) begin
        idx = b.song_sel * ToneCodes + b.entry_index;
        tone_mem[idx] = b.reload_word;
        tone_set[idx] = 1'b1;
      end
      CMD_WR_SONG: if (b.song_sel < NumSongs) begin
        song_mem[b.song_sel] = {b.last_note, b.beat_ticks, b.gap_ticks};
      end
      default: ;
    endcase
    r.tone_reload = reload_val;
    r.buzz_on     = buzz_val;
    r.playing     = play_on;
    r.song_idx    = cur_song;
    r.note_now    = cur_pos;
    r.resting     = rest_on;
    return r;
  endfunction

  task automatic send_beat(input in_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_status.push_back(play_beat(b));
  endtask

  function automatic in_t make_beat(cmd_e c);
    logic [95:0] raw;
    in_t         b;
    raw = {$urandom, $urandom, $urandom};
    b = raw[$bits(in_t)-1:0];
    b.command = c;
    return b;
  endfunction

  // Picks a rest or a tone code whose reload is already loaded for song s.
  function automatic logic [5:0] pick_tone(int unsigned s);
    int unsigned n;
    int unsigned k;
    int unsigned c;
    n = 0;
    for (c = 1; c < ToneCodes; c++) if (tone_set[s * ToneCodes + c]) n++;
    if (n == 0 || $urandom_range(0, 3) == 0) return '0;
    k = $urandom_range(0, n - 1);
    for (c = 1; c < ToneCodes; c++) begin
      if (tone_set[s * ToneCodes + c]) begin
        if (k == 0) return 6'(c);
        k--;
      end
    end
    return '0;
  endfunction

  function automatic logic [15:0] pick_beats();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_cmd(input cmd_e c);
    send_beat(make_beat(c));
  endtask

  task automatic wr_note(input int unsigned s, input int unsigned i,
                         input logic [5:0] tone, input logic [15:0] beats);
    in_t b;
    b = make_beat(CMD_WR_NOTE);
    b.song_sel    = 4'(s);
    b.entry_index = 8'(i);
    b.note_tone   = tone;
    b.note_beats  = beats;
    send_beat(b);
  endtask

  task automatic wr_tone(input int unsigned s, input int unsigned code, input logic [15:0] word);
    in_t b;
    b = make_beat(CMD_WR_TONE);
    b.song_sel    = 4'(s);
    b.entry_index = 8'(code);
    b.reload_word = word;
    send_beat(b);
  endtask

  task automatic wr_song(input int unsigned s, input logic [7:0] last,
                         input logic [15:0] beat, input logic [15:0] gap);
    in_t b;
    b = make_beat(CMD_WR_SONG);
    b.song_sel   = 4'(s);
    b.last_note  = last;
    b.beat_ticks = beat;
    b.gap_ticks  = gap;
    send_beat(b);
  endtask

  // Random beat that never makes the block read a table entry that was not written.
  task automatic send_random_beat(output bit counts);
    in_t         b;
    int unsigned pick;
    int unsigned s;
    int unsigned lim;
    int unsigned r;
    pick = $urandom_range(0, 99);
    s = ($urandom_range(0, 7) == 0) ? $urandom_range(NumSongs, MaxSel)
                                    : $urandom_range(0, NumSongs - 1);
    counts = 1'b1;
    if (pick < 45) begin
      if (play_on || $urandom_range(0, 3) == 0) begin
        b = make_beat(CMD_TICK);
        counts = play_on;
      end else begin
        b = make_beat(CMD_PLAY);
      end
    end else if (pick < 52) b = make_beat(CMD_PLAY);
    else if (pick < 56) b = make_beat(CMD_PAUSE);
    else if (pick < 61) b = make_beat(CMD_TOGGLE);
    else if (pick < 66) b = make_beat(CMD_NEXT);
    else if (pick < 70) b = make_beat(CMD_REPLAY);
    else if (pick < 73) b = make_beat(CMD_INIT);
    else if (pick < 85) begin
      b = make_beat(CMD_WR_NOTE);
      b.song_sel = 4'(s);
      if (s < NumSongs) begin
        r = $urandom_range(0, 9);
        if (r < 6 && note_fill[s] < NotesPerSong) b.entry_index = 8'(note_fill[s]);
        else if (r < 9) b.entry_index = 8'($urandom_range(0, note_fill[s] - 1));
        b.note_tone  = pick_tone(s);
        b.note_beats = pick_beats();
      end else begin
        counts = 1'b0;
      end
    end else if (pick < 91) begin
      b = make_beat(CMD_WR_TONE);
      b.song_sel = 4'(s);
      if ($urandom_range(0, 3) != 0) b.entry_index = 8'($urandom_range(0, ToneCodes - 1));
      counts = (s < NumSongs) && (b.entry_index < ToneCodes);
    end else if (pick < 97) begin
      b = make_beat(CMD_WR_SONG);
      b.song_sel = 4'(s);
      if (s < NumSongs) begin
        lim = note_fill[s] - 1;
        if (lim > 7 && $urandom_range(0, 3) != 0) lim = 7;
        b.last_note = 8'($urandom_range(0, lim));
        case ($urandom_range(0, 19))
          0:       b.beat_ticks = '0;
          1:       b.beat_ticks = 16'hFFFF;
          2:       ;
          default: b.beat_ticks = 16'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 19))
          0:       b.gap_ticks = 16'hFFFF;
          1:       ;
          default: b.gap_ticks = 16'($urandom_range(0, 3));
        endcase
      end else begin
        counts = 1'b0;
      end
    end else begin
      b = make_beat(CMD_TICK);
      b.command = 4'($urandom_range(UnusedCmdLo, UnusedCmdHi));
      counts = 1'b0;
    end
    send_beat(b);
  endtask

  task automatic test_load_tables();
    int unsigned s;
    for (s = 0; s < NumSongs; s++) begin
      wr_tone(s, 1, 16'hFFFF);
      wr_tone(s, 2, 16'h0000);
      wr_tone(s, ToneCodes - 1, 16'($urandom));
      wr_note(s, 0, 6'd1, 16'd2);
      wr_note(s, 1, 6'd0, 16'd1);
      wr_note(s, 2, 6'(ToneCodes - 1), 16'd3);
    end
    wr_song(0, 8'd2, 16'd2, 16'd1);
    wr_song(1, 8'd1, 16'd1, 16'd0);
    wr_song(2, 8'd0, 16'd1, 16'd0);
  endtask

  task automatic test_transport_commands();
    in_t b;
    send_cmd(CMD_PLAY);
    repeat (5) send_cmd(CMD_TICK);
    send_cmd(CMD_PAUSE);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TOGGLE);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TOGGLE);
    send_cmd(CMD_NEXT);
    send_cmd(CMD_REPLAY);
    send_cmd(CMD_INIT);
    b = make_beat(CMD_TICK);
    b.command = 4'(UnusedCmdLo);
    send_beat(b);
  endtask

  task automatic test_field_extremes();
    in_t b;
    wr_song(MaxSel, 8'hFF, 16'hFFFF, 16'hFFFF);
    wr_tone(0, 8'hFF, 16'hFFFF);
    wr_note(NumSongs, 8'hFF, 6'h3F, 16'hFFFF);
    wr_tone(2, 0, 16'h5A5A);
    wr_note(0, 1, 6'd0, 16'd0);
    wr_song(1, 8'd0, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_INIT);
    send_cmd(CMD_NEXT);
    send_cmd(CMD_PLAY);
    repeat (2) send_cmd(CMD_TICK);
    wr_song(1, 8'd1, 16'd0, 16'd0);
    send_cmd(CMD_REPLAY);
    send_cmd(CMD_TICK);
    wr_song(1, 8'd1, 16'd1, 16'd0);
    b = make_beat(CMD_TICK);
    b.command = 4'(UnusedCmdHi);
    send_beat(b);
  endtask

  // Lengthens song 1 and plays it through its last note while the output is held off.
  task automatic test_output_backpressure();
    int unsigned i;
    for (i = 3; i < 12; i++) wr_note(1, i, pick_tone(1), 16'd1);
    wr_song(1, 8'd11, 16'd1, 16'd0);
    send_cmd(CMD_INIT);
    send_cmd(CMD_NEXT);
    send_cmd(CMD_PLAY);
    src_idle = 0;
    hold_asked++;
    for (i = 0; i < 16; i++) send_cmd(CMD_TICK);
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned goal);
    int unsigned done;
    bit          counts;
    src_idle  = src_pct;
    sink_idle = sink_pct;
    done = 0;
    while (done < goal) begin
      send_random_beat(counts);
      if (counts) done++;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_load_tables();
    test_transport_commands();
    test_field_extremes();
    test_output_backpressure();
    test_random_traffic(15, 63, 95);
    test_random_traffic(63, 15, 95);
    test_random_traffic(0, 0, 80);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_status.size() != 0) errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk) begin : check_status
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("unexpected status beat: reload %h buzz %b play %b song %h note %h rest %b",
                   out_data.tone_reload, out_data.buzz_on, out_data.playing,
                   out_data.song_idx, out_data.note_now, out_data.resting);
        end
      end else begin
        want = pending_status.pop_front();
        if (out_data.tone_reload !== want.tone_reload || out_data.buzz_on !== want.buzz_on ||
            out_data.playing !== want.playing || out_data.song_idx !== want.song_idx ||
            out_data.note_now !== want.note_now || out_data.resting !== want.resting) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("status mismatch: expected reload %h buzz %b play %b song %h note %h rest %b",
                     want.tone_reload, want.buzz_on, want.playing,
                     want.song_idx, want.note_now, want.resting);
            $display("                 actual   reload %h buzz %b play %b song %h note %h rest %b",
                     out_data.tone_reload, out_data.buzz_on, out_data.playing,
                     out_data.song_idx, out_data.note_now, out_data.resting);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count == StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule

[melody_note_sequencer.f]
+incdir+hw/rtl
hw/rtl/mns_pkg.sv
hw/rtl/mns_store.sv
hw/rtl/melody_note_sequencer.sv
hw/rtl/mns_checker.sv
bench/melody_note_sequencer_tb.sv
